FILE: rtl/blk2s_pkg.sv
package blk2s_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_FEED     = 2'd0;
    localparam logic [1:0] CMD_FEED_FIN = 2'd1;
    localparam logic [1:0] CMD_FIN      = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_LEN = 3'd0;
    localparam logic [2:0] REG_DIG_LEN = 3'd1;
    localparam logic [2:0] REG_KEY0    = 3'd2;
    localparam logic [2:0] REG_KEY1    = 3'd3;
    localparam logic [2:0] REG_KEY2    = 3'd4;
    localparam logic [2:0] REG_KEY3    = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_DATA_W = 72;

    localparam logic [5:0] MAX_LEN   = 6'd32;
    localparam logic [6:0] BLK_BYTES = 7'd64;
    localparam logic [3:0] LAST_RND  = 4'd9;
    localparam logic [3:0] LAST_SUB  = 4'd15;

    localparam logic [31:0] IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_WRITE, ST_PRE, ST_RUN, ST_FIN, ST_OUT
    } blk2s_state_t;

    // controller -> datapath
    typedef struct packed {
        logic       init;
        logic       accept;
        logic       wr_byte;
        logic       pre;
        logic       run;
        logic       fin;
        logic       last;
        logic [3:0] rnd;
        logic [3:0] sub;
        logic [3:0] nrnd;
        logic [3:0] nsub;
        logic [1:0] wcnt;
    } blk2s_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       full;
        logic [1:0] last_idx;
    } blk2s_stat_t;

    // message schedule: word index used at position i of round r
    function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] i);
        logic [63:0] row;
        case (r)
            4'd0: row = 64'hFEDCBA9876543210;
            4'd1: row = 64'h357B20C16DF984AE;
            4'd2: row = 64'h491763EADF250C8B;
            4'd3: row = 64'h8F04A562EBCD1397;
            4'd4: row = 64'hD386CB1EFA427509;
            4'd5: row = 64'h91EF57D438B0A6C2;
            4'd6: row = 64'hB8293670A4DEF15C;
            4'd7: row = 64'hA2684F05931CE7BD;
            4'd8: row = 64'h5A417D2C803B9EF6;
            4'd9: row = 64'h0DC3E9BF5167482A;
            default: row = 64'h0;
        endcase
        return row[{i, 2'b00} +: 4];
    endfunction

endpackage

FILE: rtl/blk2s_ctrl.sv
module blk2s_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic [1:0]         s_tuser,
    input  logic               m_tready,
    input  logic               cfg_hit,
    input  blk2s_pkg::blk2s_stat_t stat,
    output blk2s_pkg::blk2s_cmd_t  cmd,
    output logic               s_tready,
    output logic               m_tvalid,
    output logic               m_tlast
);
    import blk2s_pkg::*;

    blk2s_state_t state_reg, state_next;
    logic       fin_reg, fin_next;
    logic       last_reg, last_next;
    logic [3:0] rnd_reg, rnd_next;
    logic [3:0] sub_reg, sub_next;
    logic [1:0] wcnt_reg, wcnt_next;
    logic       run_done;

    assign run_done = (rnd_reg == LAST_RND) && (sub_reg == LAST_SUB);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        CMD_FEED, CMD_FEED_FIN: state_next = stat.full ? ST_PRE : ST_WRITE;
                        CMD_FIN: state_next = ST_PRE;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE: state_next = fin_reg ? ST_PRE : ST_IDLE;
            ST_PRE:   state_next = ST_RUN;
            ST_RUN:   state_next = run_done ? ST_FIN : ST_RUN;
            ST_FIN:   state_next = last_reg ? ST_OUT : ST_WRITE;
            ST_OUT: begin
                if (m_tready && (wcnt_reg == stat.last_idx)) begin
                    state_next = ST_INIT;
                end
            end
            default: state_next = ST_INIT;
        endcase
        if (cfg_hit) begin
            state_next = ST_INIT;
        end
    end

    // counters and flags
    always_comb begin
        fin_next  = fin_reg;
        last_next = last_reg;
        rnd_next  = rnd_reg;
        sub_next  = sub_reg;
        wcnt_next = wcnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    fin_next  = (s_tuser == CMD_FEED_FIN);
                    last_next = (s_tuser == CMD_FIN);
                end
            end
            ST_WRITE: begin
                last_next = fin_reg;
                fin_next  = 1'b0;
            end
            ST_PRE: begin
                rnd_next = 4'd0;
                sub_next = 4'd0;
            end
            ST_RUN: begin
                sub_next = sub_reg + 4'd1;
                if (sub_reg == LAST_SUB) begin
                    rnd_next = rnd_reg + 4'd1;
                end
            end
            ST_FIN: wcnt_next = 2'd0;
            ST_OUT: begin
                if (m_tready) begin
                    wcnt_next = wcnt_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        cmd         = '0;
        cmd.init    = (state_reg == ST_INIT);
        cmd.accept  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.wr_byte = (state_reg == ST_WRITE);
        cmd.pre     = (state_reg == ST_PRE);
        cmd.run     = (state_reg == ST_RUN);
        cmd.fin     = (state_reg == ST_FIN);
        cmd.last    = last_reg;
        cmd.rnd     = rnd_reg;
        cmd.sub     = sub_reg;
        cmd.wcnt    = wcnt_reg;
        if (state_reg == ST_RUN) begin
            cmd.nsub = sub_reg + 4'd1;
            cmd.nrnd = (sub_reg == LAST_SUB) ? rnd_reg + 4'd1 : rnd_reg;
        end
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tlast  = (wcnt_reg == stat.last_idx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            fin_reg   <= 1'b0;
            last_reg  <= 1'b0;
            rnd_reg   <= 4'd0;
            sub_reg   <= 4'd0;
            wcnt_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            last_reg  <= last_next;
            rnd_reg   <= rnd_next;
            sub_reg   <= sub_next;
            wcnt_reg  <= wcnt_next;
        end
    end

endmodule

FILE: rtl/blk2s_dp.sv
module blk2s_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [blk2s_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blk2s_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [7:0]                    s_byte,
    input  blk2s_pkg::blk2s_cmd_t         cmd,
    output blk2s_pkg::blk2s_stat_t        stat,
    output logic [63:0]                   digest_word
);
    import blk2s_pkg::*;

    // configuration
    logic [5:0]  key_len_reg, dig_len_reg;
    logic [63:0] key_reg [4];
    logic [5:0]  kl_eff, dl_eff, dl_m1;

    // hash state
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [31:0] v_reg [16];
    logic [31:0] v_next [16];
    logic [31:0] cnt_reg, cnt_next;
    logic [6:0]  fill_reg, fill_next;
    logic        kpend_reg, kpend_next;
    logic [7:0]  byte_reg;

    // message block memory, 16 words of 4 byte lanes
    logic [3:0][7:0] mem [16];
    logic [31:0] rd_q;
    logic [3:0]  rd_idx_q;
    logic [3:0]  rd_addr;

    // G unit
    logic [31:0] mw, kw, key_half;
    logic [31:0] ga, gb, gc, gd;
    logic [31:0] upd [16];
    logic [2:0]  gsel;
    logic [31:0] pw;
    logic [63:0] dsel;

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        return (x >> n) | (x << (6'd32 - {1'b0, n}));
    endfunction

    assign kl_eff = (key_len_reg > MAX_LEN) ? MAX_LEN : key_len_reg;
    assign dl_eff = (dig_len_reg > MAX_LEN) ? MAX_LEN :
                    ((dig_len_reg == 6'd0) ? 6'd1 : dig_len_reg);
    assign dl_m1  = dl_eff - 6'd1;
    assign stat.last_idx = dl_m1[4:3];
    assign stat.full     = (fill_reg >= BLK_BYTES);
    assign pw = {8'd1, 8'd1, 2'b00, kl_eff, 2'b00, dl_eff};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg <= 6'd0;
            dig_len_reg <= MAX_LEN;
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= 64'd0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KEY_LEN: key_len_reg <= cfg_wdata[5:0];
                REG_DIG_LEN: dig_len_reg <= cfg_wdata[5:0];
                REG_KEY0:    key_reg[0]  <= cfg_wdata;
                REG_KEY1:    key_reg[1]  <= cfg_wdata;
                REG_KEY2:    key_reg[2]  <= cfg_wdata;
                REG_KEY3:    key_reg[3]  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // message word: key block while pending, else buffer bytes below fill
    assign key_half = rd_idx_q[0] ? key_reg[rd_idx_q[2:1]][63:32]
                                  : key_reg[rd_idx_q[2:1]][31:0];
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            kw[8*j +: 8] = ({rd_idx_q, 2'(j)} < kl_eff) ? key_half[8*j +: 8] : 8'h00;
            mw[8*j +: 8] = ({1'b0, rd_idx_q, 2'(j)} < fill_reg) ? rd_q[8*j +: 8] : 8'h00;
        end
    end

    // half G step on column 0, then row rotation (with diagonal turns)
    always_comb begin
        logic [31:0] x;
        logic [1:0]  sh;
        x  = kpend_reg ? kw : mw;
        ga = v_reg[0] + v_reg[4] + x;
        gd = rotr(v_reg[12] ^ ga, cmd.sub[0] ? 5'd8 : 5'd16);
        gc = v_reg[8] + gd;
        gb = rotr(v_reg[4] ^ gc, cmd.sub[0] ? 5'd7 : 5'd12);
        for (int i = 0; i < 16; i++) begin
            upd[i] = v_reg[i];
        end
        upd[0]  = ga;
        upd[4]  = gb;
        upd[8]  = gc;
        upd[12] = gd;
        gsel = cmd.sub[3:1];
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                if (!cmd.sub[0]) begin
                    sh = 2'd0;
                end else if (gsel == 3'd3) begin
                    sh = 2'(1 + r);
                end else if (gsel == 3'd7) begin
                    sh = 2'(1 - r);
                end else begin
                    sh = 2'd1;
                end
                v_next[4*r + j] = upd[4*r + 32'(2'(2'(j) + sh))];
            end
        end
    end

    // state update
    always_comb begin
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        kpend_next = kpend_reg;
        for (int i = 0; i < 8; i++) begin
            h_next[i] = h_reg[i];
        end
        if (cmd.init) begin
            for (int i = 0; i < 8; i++) begin
                h_next[i] = IV[i];
            end
            h_next[0]  = IV[0] ^ pw;
            cnt_next   = 32'd0;
            kpend_next = (kl_eff != 6'd0);
            fill_next  = (kl_eff != 6'd0) ? BLK_BYTES : 7'd0;
        end
        if (cmd.wr_byte) begin
            fill_next = fill_reg + 7'd1;
        end
        if (cmd.pre) begin
            cnt_next = cnt_reg + (cmd.last ? {25'd0, fill_reg} : {25'd0, BLK_BYTES});
        end
        if (cmd.fin) begin
            for (int i = 0; i < 8; i++) begin
                h_next[i] = h_reg[i] ^ v_reg[i] ^ v_reg[i + 8];
            end
            kpend_next = 1'b0;
            if (!cmd.last) begin
                fill_next = 7'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        fill_reg  <= fill_next;
        kpend_reg <= kpend_next;
        for (int i = 0; i < 8; i++) begin
            h_reg[i] <= h_next[i];
        end
        if (cmd.pre) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i]     <= h_reg[i];
                v_reg[i + 8] <= IV[i];
            end
            v_reg[12] <= IV[4] ^ cnt_next;
            v_reg[14] <= cmd.last ? ~IV[6] : IV[6];
        end else if (cmd.run) begin
            for (int i = 0; i < 16; i++) begin
                v_reg[i] <= v_next[i];
            end
        end
        if (cmd.accept) begin
            byte_reg <= s_byte;
        end
    end

    // block memory: byte-lane write, registered read
    assign rd_addr = sigma(cmd.nrnd, cmd.nsub);
    always_ff @(posedge aclk) begin
        if (cmd.wr_byte) begin
            mem[fill_reg[5:2]][fill_reg[1:0]] <= byte_reg;
        end
        rd_q     <= mem[rd_addr];
        rd_idx_q <= rd_addr;
    end

    // digest word with bytes past the digest length cleared
    assign dsel = {h_reg[{cmd.wcnt, 1'b1}], h_reg[{cmd.wcnt, 1'b0}]};
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            digest_word[8*b +: 8] = ({1'b0, cmd.wcnt, 3'(b)} < dl_eff) ? dsel[8*b +: 8] : 8'h00;
        end
    end

endmodule

FILE: rtl/blake2s_keyed_hash_engine.sv
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata = data_byte, s_tuser = command
// m_       out  m_tvalid/m_tready  m_tdata = digest_word, word_index; m_tlast = last_word
// cfg_     in   cfg_we             cfg_index, cfg_wdata (no read-back)
//
// A byte transfer goes through accept, then buffer write. A byte arriving on a full
// block first runs one compression: a load, 160 half-G steps on the single shared
// G unit, then a fold. Finish adds a compression, then 1 to 4 output transfers,
// then a restart through the init state. aresetn (sync, active low) and any config
// write to a listed register also restart the hash state through that init state.
// s_tready is high only while idle; m_tvalid holds until each word is taken.
module blake2s_keyed_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [blk2s_pkg::OUT_DATA_W-1:0] m_tdata, // [63:0] digest_word, [65:64] word_index
    output logic        m_tlast,   // last_word
    input  logic        cfg_we,
    input  logic [blk2s_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blk2s_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import blk2s_pkg::*;

    blk2s_cmd_t  cmd;
    blk2s_stat_t stat;
    logic        cfg_hit;
    logic [63:0] digest_word;

    // writes beyond the register list are dropped and do not restart
    assign cfg_hit = cfg_we && (cfg_index <= REG_KEY3);

    blk2s_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .cfg_hit  (cfg_hit),
        .stat     (stat),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast)
    );

    blk2s_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_byte      (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .digest_word (digest_word)
    );

    assign m_tdata = {6'd0, cmd.wcnt, digest_word};

`ifndef SYNTHESIS
    // input and output never open together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input open while digest pending");

    // after the final digest transfer the engine restarts before new input
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && !s_tready))
        else $error("no restart after final digest word");

    // a finish command never yields output in the next cycle (compression first)
    a_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_FIN)) |=> (!m_tvalid && !s_tready))
        else $error("finish skipped compression");
`endif

endmodule
